// ===== hdl/bfha_pkg.sv =====
// Shared types and constants for the best-fit hole allocator.
// Used by bfha_cell and best_fit_hole_allocator_unit; depends on nothing.
`default_nettype none

package bfha_pkg;

	localparam int SIZE_W = 17;
	localparam int SUM_W  = 21;
	localparam int ACT_W  = 2;
	localparam int STAT_W = 2;

	localparam logic [SIZE_W-1:0] MEM_RESET = 17'h10000;

	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
	localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOFIT  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EXCEED = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

	// Best candidate so far, handed from cell to cell during a search.
	typedef struct packed {
		logic              found;
		logic [SIZE_W-1:0] size;
	} token_t;

	// Table update broadcast to every cell.
	typedef struct packed {
		logic load;
		logic alloc;
	} cmd_t;

endpackage

`default_nettype wire

// ===== hdl/bfha_cell.sv =====
// One table entry of the allocator with its stage of the best-fit search chain.
// Depends on bfha_pkg.
`default_nettype none

module bfha_cell #(
	parameter int ADDR_WIDTH = 16,
	parameter int IDX_W      = 4,
	parameter int CELL_IDX   = 0
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          active,
	input  wire  [bfha_pkg::SIZE_W-1:0]  req,
	input  bfha_pkg::token_t             tok_in,
	input  wire  [IDX_W-1:0]             idx_in,
	input  wire  [ADDR_WIDTH-1:0]        bstart_in,
	output bfha_pkg::token_t             tok_out,
	output logic [IDX_W-1:0]             idx_out,
	output logic [ADDR_WIDTH-1:0]        bstart_out,
	input  bfha_pkg::cmd_t               cmd,
	input  wire  [IDX_W-1:0]             cmd_idx,
	input  wire  [ADDR_WIDTH-1:0]        cmd_start,
	input  wire  [bfha_pkg::SIZE_W-1:0]  cmd_size
);

	localparam int EXT_W = ((ADDR_WIDTH > bfha_pkg::SIZE_W) ? ADDR_WIDTH : bfha_pkg::SIZE_W) + 1;

	logic [ADDR_WIDTH-1:0]       start_q;
	logic [bfha_pkg::SIZE_W-1:0] size_q;
	bfha_pkg::token_t            tok_q;
	logic [IDX_W-1:0]            idx_q;
	logic [ADDR_WIDTH-1:0]       bstart_q;
	logic                        take;
	logic                        hit;
	logic [EXT_W-1:0]            start_sum;

	assign take = active && (size_q >= req) && (!tok_in.found || (size_q < tok_in.size));
	assign hit = (cmd_idx == IDX_W'(CELL_IDX));
	assign start_sum = EXT_W'(start_q) + EXT_W'(req);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (take) begin
			tok_q <= '{found: 1'b1, size: size_q};
		end else begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			idx_q    <= IDX_W'(CELL_IDX);
			bstart_q <= start_q;
		end else begin
			idx_q    <= idx_in;
			bstart_q <= bstart_in;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && hit) begin
			start_q <= cmd_start;
			size_q  <= cmd_size;
		end else if (cmd.alloc && hit) begin
			start_q <= start_sum[ADDR_WIDTH-1:0];
			size_q  <= size_q - req;
		end
	end

	assign tok_out    = tok_q;
	assign idx_out    = idx_q;
	assign bstart_out = bstart_q;

endmodule

`default_nettype wire

// ===== hdl/best_fit_hole_allocator_unit.sv =====
// Top level of the best-fit hole allocator: control, counters and the row of cells.
// Depends on bfha_pkg and bfha_cell.
`default_nettype none

// The table of free holes lives in a row of MAX_HOLES cells. A clear or load word
// goes from idle straight to the finishing state, where its result is written to the
// output register. An allocate word first passes through the scan state: the best-fit
// candidate walks down the row one cell per cycle, then the chosen cell is updated in
// the finishing state as the result is written to the output register. One word is
// worked on at a time; the next word is accepted as soon as the result sits in the output
// register, and a result waits in the finishing state only while that register is
// still full and not being read. memory_size is written through the cfg port,
// which is always ready.
module best_fit_hole_allocator_unit #(
	parameter int MAX_HOLES  = 16,
	parameter int ADDR_WIDTH = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [bfha_pkg::SIZE_W-1:0]  cfg_data,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [bfha_pkg::ACT_W-1:0]   action,
	input  wire  [ADDR_WIDTH-1:0]        hole_start,
	input  wire  [bfha_pkg::SIZE_W-1:0]  hole_size,
	input  wire  [bfha_pkg::SIZE_W-1:0]  request_size,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [bfha_pkg::STAT_W-1:0]  status,
	output logic [ADDR_WIDTH-1:0]        granted_address,
	output logic [bfha_pkg::SUM_W-1:0]   free_total
);

	localparam int IDX_W = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
	localparam int CNT_W = $clog2(MAX_HOLES + 1);
	localparam int EXT_W = ((ADDR_WIDTH > bfha_pkg::SIZE_W) ? ADDR_WIDTH : bfha_pkg::SIZE_W) + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]                    state_q;
	logic [IDX_W-1:0]              cnt_q;
	logic [bfha_pkg::SIZE_W-1:0]   mem_q;
	logic [CNT_W-1:0]              entries_q;
	logic [bfha_pkg::SUM_W-1:0]    free_q;
	logic [bfha_pkg::ACT_W-1:0]    act_q;
	logic [ADDR_WIDTH-1:0]         hstart_q;
	logic [bfha_pkg::SIZE_W-1:0]   hsize_q;
	logic [bfha_pkg::SIZE_W-1:0]   req_q;

	logic                          out_valid_q;
	logic [bfha_pkg::STAT_W-1:0]   status_q;
	logic [ADDR_WIDTH-1:0]         granted_q;
	logic [bfha_pkg::SUM_W-1:0]    free_out_q;

	bfha_pkg::token_t              tok_chain [0:MAX_HOLES];
	logic [IDX_W-1:0]              idx_chain [0:MAX_HOLES];
	logic [ADDR_WIDTH-1:0]         bstart_chain [0:MAX_HOLES];

	bfha_pkg::cmd_t                cmd;
	logic [IDX_W-1:0]              cmd_idx;
	logic                          fin_fire;
	logic [bfha_pkg::STAT_W-1:0]   res_status;
	logic [ADDR_WIDTH-1:0]         res_granted;
	logic [bfha_pkg::SUM_W-1:0]    res_free;
	logic [CNT_W-1:0]              res_entries;
	logic [EXT_W-1:0]              hole_end;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign fin_fire  = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign hole_end  = EXT_W'(hstart_q) + EXT_W'(hsize_q);

	assign tok_chain[0]    = '0;
	assign idx_chain[0]    = '0;
	assign bstart_chain[0] = '0;

	for (genvar i = 0; i < MAX_HOLES; i++) begin : g_cell
		bfha_cell #(
			.ADDR_WIDTH (ADDR_WIDTH),
			.IDX_W      (IDX_W),
			.CELL_IDX   (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.active     (entries_q > CNT_W'(i)),
			.req        (req_q),
			.tok_in     (tok_chain[i]),
			.idx_in     (idx_chain[i]),
			.bstart_in  (bstart_chain[i]),
			.tok_out    (tok_chain[i+1]),
			.idx_out    (idx_chain[i+1]),
			.bstart_out (bstart_chain[i+1]),
			.cmd        (cmd),
			.cmd_idx    (cmd_idx),
			.cmd_start  (hstart_q),
			.cmd_size   (hsize_q)
		);
	end

	always_comb begin
		cmd         = '0;
		cmd_idx     = entries_q[IDX_W-1:0];
		res_status  = bfha_pkg::STAT_OK;
		res_granted = '0;
		res_free    = free_q;
		res_entries = entries_q;
		case (act_q)
			bfha_pkg::ACT_CLEAR: begin
				res_free    = '0;
				res_entries = '0;
			end
			bfha_pkg::ACT_LOAD: begin
				if (entries_q == CNT_W'(MAX_HOLES)) begin
					res_status = bfha_pkg::STAT_FULL;
				end else if (hole_end > EXT_W'(mem_q)) begin
					res_status = bfha_pkg::STAT_EXCEED;
				end else begin
					cmd.load    = fin_fire;
					res_entries = entries_q + CNT_W'(1);
					res_free    = free_q + bfha_pkg::SUM_W'(hsize_q);
				end
			end
			bfha_pkg::ACT_ALLOC: begin
				if (!tok_chain[MAX_HOLES].found) begin
					res_status = bfha_pkg::STAT_NOFIT;
				end else begin
					cmd.alloc   = fin_fire;
					cmd_idx     = idx_chain[MAX_HOLES];
					res_granted = bstart_chain[MAX_HOLES];
					res_free    = free_q - bfha_pkg::SUM_W'(req_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_q <= bfha_pkg::MEM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			mem_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			entries_q   <= '0;
			free_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q   <= '0;
						state_q <= (action == bfha_pkg::ACT_ALLOC) ? ST_SCAN : ST_FIN;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + IDX_W'(1);
					if (cnt_q == IDX_W'(MAX_HOLES - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_fire) begin
						entries_q   <= res_entries;
						free_q      <= res_free;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q    <= action;
			hstart_q <= hole_start;
			hsize_q  <= hole_size;
			req_q    <= request_size;
		end
		if (fin_fire) begin
			status_q   <= res_status;
			granted_q  <= res_granted;
			free_out_q <= res_free;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign granted_address = granted_q;
	assign free_total      = free_out_q;

endmodule

`default_nettype wire

// ===== bench/best_fit_hole_allocator_unit_test.sv =====
// Self-checking bench for best_fit_hole_allocator_unit: directed and random words, each
// result checked against a best-fit table kept in the bench, with random stalls on both sides.
// Depends on bfha_pkg and best_fit_hole_allocator_unit.
`timescale 1ns / 1ps

module best_fit_hole_allocator_unit_test;

	localparam int MAX_HOLES  = 16;
	localparam int ADDR_WIDTH = 16;
	localparam int SIZE_TOP   = 65536;
	localparam logic [bfha_pkg::SIZE_W-1:0] SIZE_FULL = 17'h10000;
	localparam int NO_HOLE    = -1;
	localparam int LONG_HOLD  = 300;
	localparam int SETTLE     = 2 * MAX_HOLES + 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [bfha_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [bfha_pkg::STAT_W-1:0] status;
		logic [ADDR_WIDTH-1:0]       address;
		logic [bfha_pkg::SUM_W-1:0]  total;
	} hole_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [bfha_pkg::SIZE_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [bfha_pkg::ACT_W-1:0] action = bfha_pkg::ACT_CLEAR;
	logic [ADDR_WIDTH-1:0] hole_start = '0;
	logic [bfha_pkg::SIZE_W-1:0] hole_size = '0;
	logic [bfha_pkg::SIZE_W-1:0] request_size = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [bfha_pkg::STAT_W-1:0] status;
	logic [ADDR_WIDTH-1:0] granted_address;
	logic [bfha_pkg::SUM_W-1:0] free_total;

	// Bench copy of the hole table and the memory size register.
	logic [ADDR_WIDTH-1:0]       hole_base [MAX_HOLES];
	logic [bfha_pkg::SIZE_W-1:0] hole_len [MAX_HOLES];
	int                          table_fill = 0;
	logic [bfha_pkg::SUM_W-1:0]  free_space = '0;
	logic [bfha_pkg::SIZE_W-1:0] mem_limit = bfha_pkg::MEM_RESET;

	hole_result_t pending_results [$];
	int fail_count = 0;
	int cycle_count = 0;
	bit sender_calm = 1'b0;
	int hold_orders = 0;

	best_fit_hole_allocator_unit #(
		.MAX_HOLES (MAX_HOLES),
		.ADDR_WIDTH(ADDR_WIDTH)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.hole_start     (hole_start),
		.hole_size      (hole_size),
		.request_size   (request_size),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.granted_address(granted_address),
		.free_total     (free_total)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic hole_result_t predict_hole_result(
			input logic [bfha_pkg::ACT_W-1:0] act,
			input logic [ADDR_WIDTH-1:0] start, input logic [bfha_pkg::SIZE_W-1:0] size,
			input logic [bfha_pkg::SIZE_W-1:0] req);
		hole_result_t r;
		int best;
		r.status = bfha_pkg::STAT_OK;
		r.address = '0;
		best = NO_HOLE;
		case (act)
			bfha_pkg::ACT_CLEAR: begin
				table_fill = 0;
				free_space = '0;
			end
			bfha_pkg::ACT_LOAD: begin
				if (table_fill >= MAX_HOLES) begin
					r.status = bfha_pkg::STAT_FULL;
				end else if (18'(start) + 18'(size) > 18'(mem_limit)) begin
					r.status = bfha_pkg::STAT_EXCEED;
				end else begin
					hole_base[table_fill] = start;
					hole_len[table_fill] = size;
					table_fill++;
					free_space = free_space + bfha_pkg::SUM_W'(size);
				end
			end
			bfha_pkg::ACT_ALLOC: begin
				for (int i = 0; i < table_fill; i++)
					if (hole_len[i] >= req && (best == NO_HOLE || hole_len[i] < hole_len[best]))
						best = i;
				if (best == NO_HOLE) begin
					r.status = bfha_pkg::STAT_NOFIT;
				end else begin
					r.address = hole_base[best];
					hole_base[best] = hole_base[best] + ADDR_WIDTH'(req);
					hole_len[best] = hole_len[best] - req;
					free_space = free_space - bfha_pkg::SUM_W'(req);
				end
			end
			default: ;
		endcase
		r.total = free_space;
		return r;
	endfunction

	// Called just after a rising edge; returns just after the edge that took the word,
	// or after the chosen gap, leaving in_valid high when no gap follows.
	task automatic send_word(input logic [bfha_pkg::ACT_W-1:0] act,
			input logic [ADDR_WIDTH-1:0] start, input logic [bfha_pkg::SIZE_W-1:0] size,
			input logic [bfha_pkg::SIZE_W-1:0] req);
		int gap;
		in_valid <= 1'b1;
		action <= act;
		hole_start <= start;
		hole_size <= size;
		request_size <= req;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(predict_hole_result(act, start, size, req));
		gap = sender_calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_memory_size(input logic [bfha_pkg::SIZE_W-1:0] value);
		wait_for_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		mem_limit = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_word();
		int pick;
		int idx;
		int span;
		int top;
		logic [ADDR_WIDTH-1:0] start;
		logic [bfha_pkg::SIZE_W-1:0] size;
		logic [bfha_pkg::SIZE_W-1:0] req;
		pick = $urandom_range(0, 99);
		start = ADDR_WIDTH'($urandom);
		size = bfha_pkg::SIZE_W'($urandom_range(0, SIZE_TOP));
		req = bfha_pkg::SIZE_W'($urandom_range(0, SIZE_TOP));
		if (pick < 3) begin
			send_word(bfha_pkg::ACT_CLEAR, start, size, req);
		end else if (pick < 6) begin
			send_word(ACT_UNUSED, start, size, req);
		end else if (pick < 11) begin
			send_word(bfha_pkg::ACT_LOAD, start, size, req);
		end else if (pick < 45) begin
			top = (int'(mem_limit) > SIZE_TOP - 1) ? SIZE_TOP - 1 : int'(mem_limit);
			start = ADDR_WIDTH'($urandom_range(0, top));
			span = int'(mem_limit) - int'(start);
			case ($urandom_range(0, 2))
				0: size = bfha_pkg::SIZE_W'($urandom_range(0, (span < 255) ? span : 255));
				1: size = bfha_pkg::SIZE_W'($urandom_range(0, span));
				default: size = bfha_pkg::SIZE_W'(span);
			endcase
			send_word(bfha_pkg::ACT_LOAD, start, size, req);
		end else begin
			if (table_fill > 0) begin
				idx = $urandom_range(0, table_fill - 1);
				case ($urandom_range(0, 9))
					0, 1, 2, 3: req = hole_len[idx];
					4, 5, 6: req = bfha_pkg::SIZE_W'($urandom_range(0, int'(hole_len[idx])));
					7: req = (hole_len[idx] == SIZE_FULL) ? hole_len[idx] :
						hole_len[idx] + 17'd1;
					8: req = '0;
					default: ;
				endcase
			end
			send_word(bfha_pkg::ACT_ALLOC, start, size, req);
		end
	endtask

	task automatic test_empty_table();
		send_word(bfha_pkg::ACT_ALLOC, '0, '0, '0);
		send_word(ACT_UNUSED, '1, SIZE_FULL, SIZE_FULL);
		send_word(bfha_pkg::ACT_ALLOC, '1, SIZE_FULL, SIZE_FULL);
	endtask

	task automatic test_load_limits();
		set_memory_size(bfha_pkg::MEM_RESET);
		send_word(bfha_pkg::ACT_LOAD, '0, SIZE_FULL, '0);
		send_word(bfha_pkg::ACT_LOAD, '1, 17'd1, '0);
		send_word(bfha_pkg::ACT_LOAD, '1, 17'd2, '0);
		send_word(bfha_pkg::ACT_LOAD, 16'd100, '0, '0);
		send_word(bfha_pkg::ACT_ALLOC, '0, '0, '0);
		send_word(bfha_pkg::ACT_ALLOC, '0, '0, SIZE_FULL);
		send_word(bfha_pkg::ACT_CLEAR, '0, '0, '0);
	endtask

	task automatic test_best_fit_choice();
		send_word(bfha_pkg::ACT_LOAD, 16'h1000, 17'h100, '0);
		send_word(bfha_pkg::ACT_LOAD, 16'h2000, 17'h80, '0);
		send_word(bfha_pkg::ACT_LOAD, 16'h3000, 17'h80, '0);
		send_word(bfha_pkg::ACT_LOAD, 16'h4000, 17'h7f, '0);
		send_word(bfha_pkg::ACT_ALLOC, '0, '0, 17'h80);
		send_word(bfha_pkg::ACT_ALLOC, '0, '0, 17'h80);
		send_word(bfha_pkg::ACT_ALLOC, '0, '0, 17'h81);
		send_word(bfha_pkg::ACT_ALLOC, '0, '0, 17'h100);
	endtask

	task automatic test_full_table();
		for (int i = 4; i < MAX_HOLES; i++)
			send_word(bfha_pkg::ACT_LOAD, ADDR_WIDTH'(i * 16'h1000), 17'h800, '0);
		send_word(bfha_pkg::ACT_LOAD, '1, SIZE_FULL, '0);
		send_word(bfha_pkg::ACT_LOAD, 16'h0010, 17'h10, '0);
		send_word(bfha_pkg::ACT_ALLOC, '0, '0, 17'h800);
		send_word(bfha_pkg::ACT_CLEAR, '0, '0, '0);
	endtask

	task automatic test_back_pressure();
		wait_for_results();
		hold_orders <= hold_orders + 1;
		sender_calm = 1'b1;
		for (int i = 0; i < 12; i++)
			send_random_word();
		sender_calm = 1'b0;
		wait_for_results();
	endtask

	task automatic test_random_phase(input logic [bfha_pkg::SIZE_W-1:0] value, input int count);
		set_memory_size(value);
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0)
				sender_calm = ($urandom_range(0, 3) == 0);
			send_random_word();
		end
		sender_calm = 1'b0;
	endtask

	// Receiver: random stalls, calm stretches, and a long hold-off when the stimulus asks.
	always @(posedge clk) begin
		static int stall_left = 0;
		static int hold_seen = 0;
		static int mode_left = 0;
		static bit calm = 1'b0;
		if (hold_orders != hold_seen) begin
			hold_seen = hold_orders;
			stall_left = LONG_HOLD;
		end
		if (mode_left == 0) begin
			calm = ($urandom_range(0, 3) == 0);
			mode_left = $urandom_range(50, 300);
		end else begin
			mode_left--;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!calm && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		hole_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected word: status %0d address %0h total %0d",
					status, granted_address, free_total);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
				if (granted_address !== want.address) begin
					$error("granted_address: expected %0h, got %0h", want.address,
						granted_address);
					fail_count++;
				end
				if (free_total !== want.total) begin
					$error("free_total: expected %0d, got %0d", want.total, free_total);
					fail_count++;
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_load_limits();
		test_best_fit_choice();
		test_full_table();
		test_back_pressure();
		test_random_phase(bfha_pkg::MEM_RESET, 240);
		test_random_phase('0, 120);
		test_random_phase(17'd1, 120);
		test_random_phase(17'd65535, 300);
		test_back_pressure();
		test_random_phase(17'd4096, 300);
		test_random_phase(17'd257, 240);
		test_random_phase(bfha_pkg::SIZE_W'($urandom_range(0, SIZE_TOP)), 300);
		test_random_phase(bfha_pkg::MEM_RESET, 300);
		wait_for_results();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
